### hdl/ntts_pkg.sv
// Shared types, constants and the slot pair lookup for the TDM turn schedule.
// No dependencies; used by every module of the block.
package ntts_pkg;

  localparam int MESH_ROWS  = 4;
  localparam int ID_W       = 8;
  localparam int SLOT_LEN_W = 16;
  localparam int CYCLE_W    = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SLOT_COUNT = 10;
  localparam int RES_W      = 4;
  localparam int QLOW_W     = 4;
  localparam int REGION_W   = $clog2(MESH_ROWS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUTER_ID       = 4'd0,
    REG_SLOT_LENGTH     = 4'd1,
    REG_CFC_ENABLE      = 4'd2,
    REG_FASTPASS_ENABLE = 4'd3
  } cfg_reg_t;

  localparam logic [RES_W-1:0] SLOT_TABLE [MESH_ROWS][MESH_ROWS] = '{
    '{4'd0, 4'd1, 4'd3, 4'd6},
    '{4'd1, 4'd2, 4'd4, 4'd7},
    '{4'd3, 4'd4, 4'd5, 4'd8},
    '{4'd6, 4'd7, 4'd8, 4'd9}
  };

  typedef struct packed {
    logic                  valid;
    logic [CYCLE_W-1:0]    dividend;
    logic [SLOT_LEN_W-1:0] rem;
    logic [RES_W-1:0]      res10;
    logic [QLOW_W-1:0]     qlow;
  } stage_t;

  typedef struct packed {
    logic                found;
    logic [REGION_W-1:0] row;
    logic [REGION_W-1:0] col;
  } slot_pair_t;

  function automatic slot_pair_t slot_pair(input logic [RES_W-1:0] slot);
    slot_pair_t p;
    p.found = 1'b0;
    p.row   = '0;
    p.col   = '0;
    for (int i = 0; i < MESH_ROWS; i++) begin
      for (int j = 0; j < MESH_ROWS; j++) begin
        if (SLOT_TABLE[i][j] == slot) begin
          p.found = 1'b1;
          p.row   = REGION_W'(i);
          p.col   = REGION_W'(j);
        end
      end
    end
    return p;
  endfunction

endpackage

### hdl/ntts_div_stage.sv
// One restoring-division step: takes one quotient bit of cycle / slot_length.
// Also tracks the quotient mod 10 and its low bits. Depends on ntts_pkg.
module ntts_div_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic [ntts_pkg::SLOT_LEN_W-1:0]   divisor,
  input  ntts_pkg::stage_t                  d,
  output ntts_pkg::stage_t                  q
);

  logic [ntts_pkg::SLOT_LEN_W:0]  trial;
  logic [ntts_pkg::SLOT_LEN_W:0]  diff;
  logic                           qbit;
  logic [ntts_pkg::RES_W:0]       res2;
  ntts_pkg::stage_t               q_next;

  always_comb begin
    trial = {d.rem, d.dividend[ntts_pkg::CYCLE_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
    res2  = {d.res10, qbit};
    if (res2 >= (ntts_pkg::RES_W+1)'(ntts_pkg::SLOT_COUNT)) begin
      res2 = res2 - (ntts_pkg::RES_W+1)'(ntts_pkg::SLOT_COUNT);
    end
    q_next.valid    = d.valid;
    q_next.dividend = {d.dividend[ntts_pkg::CYCLE_W-2:0], 1'b0};
    q_next.rem      = qbit ? diff[ntts_pkg::SLOT_LEN_W-1:0] : trial[ntts_pkg::SLOT_LEN_W-1:0];
    q_next.res10    = res2[ntts_pkg::RES_W-1:0];
    q_next.qlow     = {d.qlow[ntts_pkg::QLOW_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (advance) begin
      q <= q_next;
    end
  end

endmodule

### hdl/ntts_turn.sv
// Final stage: slot boundary check and both turn decisions into the output register.
// Depends on ntts_pkg.
module ntts_turn (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic [ntts_pkg::ID_W-1:0]        router_id,
  input  logic [ntts_pkg::SLOT_LEN_W-1:0]  slot_length,
  input  logic                             cfc_enable,
  input  logic                             fastpass_enable,
  input  ntts_pkg::stage_t                 d,
  output logic                             out_valid,
  output logic                             cfc_turn,
  output logic                             fastpass_turn
);

  logic                               boundary;
  logic [ntts_pkg::REGION_W-1:0]      cfc_region;
  logic [ntts_pkg::REGION_W-1:0]      fp_col;
  ntts_pkg::slot_pair_t               pair;
  logic                               cfc_next;
  logic                               fp_next;

  always_comb begin
    boundary   = (slot_length != '0) && (d.rem == '0) && (router_id[7:6] == 2'b00);
    cfc_region = router_id[1:0] - router_id[3:2];
    pair       = ntts_pkg::slot_pair(d.res10);
    fp_col     = d.qlow[3:2] + router_id[1:0];
    cfc_next   = boundary && cfc_enable && pair.found &&
                 ((cfc_region == pair.row) || (cfc_region == pair.col));
    fp_next    = boundary && fastpass_enable && (router_id[5:4] == 2'b00) &&
                 (router_id[3:2] == fp_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cfc_turn      <= cfc_next;
      fastpass_turn <= fp_next;
    end
  end

endmodule

### hdl/noc_tdm_turn_schedule_core.sv
// Pipeline: 32 one-bit division stages for cycle / slot_length, then one
//   decision stage.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, active high; clears all valid bits and loads
//   router_id 0, slot_length 1 and both enables 0.
module noc_tdm_turn_schedule_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ntts_pkg::CYCLE_W-1:0]     cycle_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             cfc_turn,
  output logic                             fastpass_turn,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ntts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ntts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [ntts_pkg::ID_W-1:0]        router_id;
  logic [ntts_pkg::SLOT_LEN_W-1:0]  slot_length;
  logic                             cfc_enable;
  logic                             fastpass_enable;
  logic                             advance;
  ntts_pkg::stage_t                 stage [ntts_pkg::CYCLE_W+1];

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      router_id       <= '0;
      slot_length     <= ntts_pkg::SLOT_LEN_W'(1);
      cfc_enable      <= 1'b0;
      fastpass_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ntts_pkg::REG_ROUTER_ID:       router_id       <= cfg_data[ntts_pkg::ID_W-1:0];
        ntts_pkg::REG_SLOT_LENGTH:     slot_length     <= cfg_data;
        ntts_pkg::REG_CFC_ENABLE:      cfc_enable      <= cfg_data[0];
        ntts_pkg::REG_FASTPASS_ENABLE: fastpass_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stage[0].valid    = in_valid;
    stage[0].dividend = cycle_number;
    stage[0].rem      = '0;
    stage[0].res10    = '0;
    stage[0].qlow     = '0;
  end

  for (genvar g = 0; g < ntts_pkg::CYCLE_W; g++) begin : g_div
    ntts_div_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .divisor (slot_length),
      .d       (stage[g]),
      .q       (stage[g+1])
    );
  end

  ntts_turn u_turn (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .router_id       (router_id),
    .slot_length     (slot_length),
    .cfc_enable      (cfc_enable),
    .fastpass_enable (fastpass_enable),
    .d               (stage[ntts_pkg::CYCLE_W]),
    .out_valid       (out_valid),
    .cfc_turn        (cfc_turn),
    .fastpass_turn   (fastpass_turn)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_on_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_cfc_needs_config: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cfc_turn) |-> (cfc_enable && (router_id[7:6] == 2'b00)))
    else $error("controller turn granted with schedule disabled or id out of range");

  a_fp_needs_config: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fastpass_turn) |-> (fastpass_enable && (router_id[7:4] == 4'h0)))
    else $error("fast-pass turn granted with schedule disabled or id out of range");
`endif

endmodule
